// ----- hdl/jiq_pkg.sv -----
// ----------------------------------------------------------------------------
// jiq_pkg: joystick input qualifier shared definitions
// Word types, class and mode codes, register indexes and sizes.
// ----------------------------------------------------------------------------
package jiq_pkg;

   localparam int HISTORY_DEPTH = 5;
   localparam int SAMPLE_BITS   = 12;
   localparam int WAIT_BITS     = 8;

   localparam int ADC_BITS  = 12;
   localparam int THR_BITS  = 12;
   localparam int TICK_BITS = 8;
   localparam int CLS_BITS  = 2;
   localparam int HIST_BITS = CLS_BITS * HISTORY_DEPTH;

   localparam logic [ADC_BITS-1:0] SAMPLE_MASK =
      (SAMPLE_BITS >= ADC_BITS) ? {ADC_BITS{1'b1}}
                                : ADC_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);

   localparam logic [CLS_BITS-1:0] CLS_NEUTRAL = 2'd0;
   localparam logic [CLS_BITS-1:0] CLS_RIGHT   = 2'd1;
   localparam logic [CLS_BITS-1:0] CLS_LEFT    = 2'd2;
   localparam logic [CLS_BITS-1:0] CLS_ATTACK  = 2'd3;

   localparam int MODE_BITS = 2;
   localparam logic [MODE_BITS-1:0] MODE_IDLE    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_CONFIRM = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_HOLD    = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_RELEASE = 2'd3;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 12;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RIGHT_THRESHOLD       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEFT_THRESHOLD        = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONFIRM_TICKS         = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEUTRAL_CONFIRM_TICKS = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_HOLD_TICKS    = 3'd4;

   localparam logic [THR_BITS-1:0]  RIGHT_THRESHOLD_RESET       = 12'd4050;
   localparam logic [THR_BITS-1:0]  LEFT_THRESHOLD_RESET        = 12'd2000;
   localparam logic [TICK_BITS-1:0] CONFIRM_TICKS_RESET         = 8'd2;
   localparam logic [TICK_BITS-1:0] NEUTRAL_CONFIRM_TICKS_RESET = 8'd40;
   localparam logic [TICK_BITS-1:0] RELEASE_HOLD_TICKS_RESET    = 8'd30;

   typedef struct packed {
      logic [ADC_BITS-1:0] adc_sample;
      logic                button_pressed;
   } req_word_type;

   typedef struct packed {
      logic [HIST_BITS-1:0] history;
      logic                 symbol_pushed;
      logic [CLS_BITS-1:0]  pushed_symbol;
      logic [CLS_BITS-1:0]  current_class;
   } rsp_word_type;

   typedef struct packed {
      logic [THR_BITS-1:0]  right_threshold;
      logic [THR_BITS-1:0]  left_threshold;
      logic [WAIT_BITS-1:0] confirm_ticks;
      logic [WAIT_BITS-1:0] neutral_confirm_ticks;
      logic [WAIT_BITS-1:0] release_hold_ticks;
   } cfg_type;

endpackage

// ----- hdl/jiq_csr.sv -----
// ----------------------------------------------------------------------------
// jiq_csr: configuration registers
// Holds thresholds and wait lengths; written through the csr channel.
// ----------------------------------------------------------------------------
module jiq_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [jiq_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [jiq_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output jiq_pkg::cfg_type                     cfg
);

   jiq_pkg::cfg_type cfg_ff;
   jiq_pkg::cfg_type cfg_in;
   logic [jiq_pkg::TICK_BITS-1:0] ticks;

   assign csr_ready = 1'b1;
   assign ticks     = csr_wdata[jiq_pkg::TICK_BITS-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            jiq_pkg::CSR_RIGHT_THRESHOLD:
               cfg_in.right_threshold = csr_wdata[jiq_pkg::THR_BITS-1:0];
            jiq_pkg::CSR_LEFT_THRESHOLD:
               cfg_in.left_threshold = csr_wdata[jiq_pkg::THR_BITS-1:0];
            jiq_pkg::CSR_CONFIRM_TICKS:
               cfg_in.confirm_ticks = jiq_pkg::WAIT_BITS'(ticks);
            jiq_pkg::CSR_NEUTRAL_CONFIRM_TICKS:
               cfg_in.neutral_confirm_ticks = jiq_pkg::WAIT_BITS'(ticks);
            jiq_pkg::CSR_RELEASE_HOLD_TICKS:
               cfg_in.release_hold_ticks = jiq_pkg::WAIT_BITS'(ticks);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.right_threshold       <= jiq_pkg::RIGHT_THRESHOLD_RESET;
         cfg_ff.left_threshold        <= jiq_pkg::LEFT_THRESHOLD_RESET;
         cfg_ff.confirm_ticks         <= jiq_pkg::WAIT_BITS'(jiq_pkg::CONFIRM_TICKS_RESET);
         cfg_ff.neutral_confirm_ticks <=
            jiq_pkg::WAIT_BITS'(jiq_pkg::NEUTRAL_CONFIRM_TICKS_RESET);
         cfg_ff.release_hold_ticks    <=
            jiq_pkg::WAIT_BITS'(jiq_pkg::RELEASE_HOLD_TICKS_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/jiq_core.sv -----
// ----------------------------------------------------------------------------
// jiq_core: classifier and debounce machine
// Sorts a word into a class, runs the confirm/hold/release machine and
// keeps the symbol history. Produces the result word for the current step.
// ----------------------------------------------------------------------------
module jiq_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  jiq_pkg::req_word_type   word,
   input  jiq_pkg::cfg_type        cfg,
   output jiq_pkg::rsp_word_type   result
);

   logic [jiq_pkg::MODE_BITS-1:0] mode_ff, mode_in;
   logic [jiq_pkg::CLS_BITS-1:0]  cand_ff, cand_in;
   logic [jiq_pkg::CLS_BITS-1:0]  latched_ff, latched_in;
   logic [jiq_pkg::WAIT_BITS-1:0] wait_ff, wait_in;
   logic [jiq_pkg::HIST_BITS-1:0] hist_ff, hist_in;

   logic [jiq_pkg::ADC_BITS-1:0]  sample;
   logic [jiq_pkg::CLS_BITS-1:0]  cls;
   logic                          pushed;
   logic [jiq_pkg::CLS_BITS-1:0]  sym;

   assign sample = word.adc_sample & jiq_pkg::SAMPLE_MASK;

   // right is tested before left, so crossed thresholds favor right; a pressed button overrides both
   always_comb begin
      if (word.button_pressed)
         cls = jiq_pkg::CLS_ATTACK;
      else if (sample > cfg.right_threshold)
         cls = jiq_pkg::CLS_RIGHT;
      else if (sample <= cfg.left_threshold)
         cls = jiq_pkg::CLS_LEFT;
      else
         cls = jiq_pkg::CLS_NEUTRAL;
   end

   always_comb begin
      mode_in    = mode_ff;
      cand_in    = cand_ff;
      latched_in = latched_ff;
      wait_in    = wait_ff;
      hist_in    = hist_ff;
      pushed     = 1'b0;
      sym        = jiq_pkg::CLS_NEUTRAL;
      case (mode_ff)
         jiq_pkg::MODE_CONFIRM: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - 1'b1;
            end else if (cls == cand_ff) begin
               pushed     = 1'b1;
               sym        = cand_ff;
               hist_in    = jiq_pkg::HIST_BITS'({hist_ff, cand_ff});
               latched_in = cand_ff;
               mode_in    = jiq_pkg::MODE_HOLD;
            end else begin
               mode_in = jiq_pkg::MODE_IDLE;
            end
         end
         jiq_pkg::MODE_HOLD: begin
            if (cls != latched_ff) begin
               if (latched_ff == jiq_pkg::CLS_ATTACK) begin
                  wait_in = cfg.release_hold_ticks;
                  mode_in = jiq_pkg::MODE_RELEASE;
               end else begin
                  mode_in = jiq_pkg::MODE_IDLE;
               end
            end
         end
         jiq_pkg::MODE_RELEASE: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - 1'b1;
            end else if (cls == jiq_pkg::CLS_ATTACK) begin
               latched_in = jiq_pkg::CLS_ATTACK;
               mode_in    = jiq_pkg::MODE_HOLD;
            end else begin
               mode_in = jiq_pkg::MODE_IDLE;
            end
         end
         default: begin
            cand_in = cls;
            wait_in = (cls == jiq_pkg::CLS_NEUTRAL) ? cfg.neutral_confirm_ticks
                                                    : cfg.confirm_ticks;
            mode_in = jiq_pkg::MODE_CONFIRM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= jiq_pkg::MODE_IDLE;
         cand_ff    <= jiq_pkg::CLS_NEUTRAL;
         latched_ff <= jiq_pkg::CLS_NEUTRAL;
         wait_ff    <= '0;
         hist_ff    <= '0;
      end else if (step) begin
         mode_ff    <= mode_in;
         cand_ff    <= cand_in;
         latched_ff <= latched_in;
         wait_ff    <= wait_in;
         hist_ff    <= hist_in;
      end
   end

   assign result.history       = hist_in;
   assign result.symbol_pushed = pushed;
   assign result.pushed_symbol = sym;
   assign result.current_class = cls;

endmodule

// ----- hdl/joystick_input_qualifier_unit.sv -----
// ----------------------------------------------------------------------------
// joystick_input_qualifier_unit: joystick sample debounce and history
// Input register, qualifier core and result register, plus config registers.
// ----------------------------------------------------------------------------
// One sample word per clock cycle in, one result word per word out, in
// order. A word passes through the input register and then through the
// classifier and debounce machine into the result register. Both
// registers move whenever the result register is empty or being taken,
// so the sustained rate is one word per cycle while rsp_ready stays high.
// Configuration is written through the csr channel, which is always
// ready, and should only be written while no word is in flight.
module joystick_input_qualifier_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  jiq_pkg::req_word_type                req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output jiq_pkg::rsp_word_type                rsp_word,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [jiq_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [jiq_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   jiq_pkg::cfg_type      cfg;
   jiq_pkg::req_word_type in_word_ff;
   jiq_pkg::rsp_word_type rsp_word_ff;
   jiq_pkg::rsp_word_type core_result;
   logic                  in_valid_ff, in_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  advance;
   logic                  step;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready)
         in_valid_in = 1'b1;
      else if (step)
         in_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (step)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready)
         in_word_ff <= req_word;
      if (step)
         rsp_word_ff <= core_result;
   end

   jiq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   jiq_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .word   (in_word_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
